[design/nbc_pkg.sv]
// ----------------------------------------------------------------------------
// nbc_pkg
// Shared types, codes, constants and the fixed-point log2 function of the
// categorical naive Bayes classifier.
// ----------------------------------------------------------------------------
package nbc_pkg;

  // Default sizing of the counter store.
  localparam int NUM_FEATURES_DEF = 16;
  localparam int NUM_VALUES_DEF   = 4;
  localparam int NUM_CLASSES_DEF  = 4;
  localparam int COUNT_BITS_DEF   = 16;

  // Widest argument of the log unit: a full-width count plus a small offset.
  localparam int LOG_ARG_W = 33;
  localparam int LOG_W     = 16;
  localparam int SCORE_W   = 22;

  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 2;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_CLASSES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FEATURES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VALUES   = 2'd2;
  // Index with no register behind it; a write there changes nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED   = 2'd3;

  // Operation codes.
  localparam logic [1:0] OP_TRAIN   = 2'd0;
  localparam logic [1:0] OP_PREDICT = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;
  // Unassigned code; the block answers it with a zero result.
  localparam logic [1:0] OP_UNKNOWN = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [2:0] CLASSES_RST  = 3'd2;
  localparam logic [4:0] FEATURES_RST = 5'd16;
  localparam logic [2:0] VALUES_RST   = 3'd3;

  typedef struct packed {
    logic [1:0]  operation;
    logic [1:0]  class_label;
    logic [31:0] feature_values;
  } in_item_t;

  typedef struct packed {
    logic [1:0] predicted_class;
    logic       label_matches;
  } out_result_t;

  // Strobes from the sequencer to the scoring datapath.
  typedef struct packed {
    logic prior_ld;
    logic denom_ld;
    logic rd_valid;
    logic class_done;
    logic first_class;
  } score_ctl_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_TR_CLS,
    S_TR_RD,
    S_TR_WR,
    S_PR_PRIOR,
    S_PR_DENOM,
    S_PR_ISSUE,
    S_PR_DRAIN,
    S_PR_CLASS,
    S_FIN
  } fsm_state_t;

  // round(2048 * log2(1 + m/32)) for the five bits below the leading one.
  localparam logic [10:0] FRAC_TABLE [32] = '{
    11'd0,    11'd91,   11'd179,  11'd265,  11'd348,  11'd429,  11'd508,  11'd585,
    11'd659,  11'd732,  11'd803,  11'd873,  11'd941,  11'd1007, 11'd1072, 11'd1136,
    11'd1198, 11'd1259, 11'd1319, 11'd1377, 11'd1435, 11'd1491, 11'd1546, 11'd1600,
    11'd1653, 11'd1706, 11'd1757, 11'd1808, 11'd1857, 11'd1906, 11'd1954, 11'd2001
  };

  // Unsigned Q5.11 log2, saturating at all ones. Zero maps to zero.
  function automatic logic [LOG_W-1:0] log2_q(input logic [LOG_ARG_W-1:0] x);
    logic [5:0]           p;
    logic [LOG_ARG_W+4:0] sh;
    logic [4:0]           m;
    logic [16:0]          r;
    p = '0;
    for (int i = 1; i < LOG_ARG_W; i++) begin
      if (x[i]) begin
        p = 6'(i);
      end
    end
    sh = {x, 5'b0} >> p;
    m  = sh[4:0];
    r  = {p, 11'b0} + 17'(FRAC_TABLE[m]);
    return r[16] ? {LOG_W{1'b1}} : r[LOG_W-1:0];
  endfunction

endpackage

[design/nbc_ram.sv]
// ----------------------------------------------------------------------------
// nbc_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module nbc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/nbc_score.sv]
// ----------------------------------------------------------------------------
// nbc_score
// Scoring datapath: log terms, per-class accumulator and the running best.
// ----------------------------------------------------------------------------
module nbc_score #(
  parameter int NUM_FEATURES = nbc_pkg::NUM_FEATURES_DEF,
  parameter int NUM_CLASSES  = nbc_pkg::NUM_CLASSES_DEF,
  parameter int COUNT_BITS   = nbc_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  nbc_pkg::score_ctl_t            ctl,
  input  logic [$clog2(NUM_CLASSES)-1:0] cls,
  input  logic [nbc_pkg::LOG_ARG_W-1:0]  log_arg,
  input  logic [COUNT_BITS-1:0]          rdata,
  output logic                           busy,
  output logic [$clog2(NUM_CLASSES)-1:0] best_cls
);

  localparam int CLS_W = $clog2(NUM_CLASSES);
  localparam int LW    = nbc_pkg::LOG_W;
  localparam int ACC_W = LW + $clog2(NUM_FEATURES + 1) + 2;
  localparam int SW    = nbc_pkg::SCORE_W;

  localparam logic signed [ACC_W-1:0] SMAX = ACC_W'((64'sd1 <<< (SW - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] SMIN = ACC_W'(-(64'sd1 <<< (SW - 1)));

  logic [LW-1:0]          arg_log;
  logic [LW-1:0]          cnt_log;
  logic [LW-1:0]          denom_r;
  logic signed [LW:0]     term_r;
  logic                   term_v_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] sat;
  logic signed [SW-1:0]   best_r;
  logic [CLS_W-1:0]       best_cls_r;

  assign arg_log = nbc_pkg::log2_q(log_arg);
  assign cnt_log = nbc_pkg::log2_q(nbc_pkg::LOG_ARG_W'(rdata) + 1'b1);

  always_comb begin
    if (acc_r > SMAX) begin
      sat = SMAX;
    end else if (acc_r < SMIN) begin
      sat = SMIN;
    end else begin
      sat = acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_v_r <= 1'b0;
    end else begin
      term_v_r <= ctl.rd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.denom_ld) begin
      denom_r <= arg_log;
    end
    if (ctl.rd_valid) begin
      term_r <= $signed({1'b0, cnt_log}) - $signed({1'b0, denom_r});
    end
    if (ctl.prior_ld) begin
      acc_r <= $signed({{(ACC_W - LW){1'b0}}, arg_log});
    end else if (term_v_r) begin
      acc_r <= acc_r + {{(ACC_W - LW - 1){term_r[LW]}}, term_r};
    end
    if (ctl.class_done && (ctl.first_class || $signed(sat[SW-1:0]) > best_r)) begin
      best_r     <= sat[SW-1:0];
      best_cls_r <= cls;
    end
  end

  assign busy     = term_v_r;
  assign best_cls = best_cls_r;

endmodule

[design/naive_bayes_categorical_classifier_core.sv]
// ----------------------------------------------------------------------------
// naive_bayes_categorical_classifier_core
// Categorical naive Bayes engine with Laplace smoothing and counter memory.
// ----------------------------------------------------------------------------
// Items arrive on the in_ channel (valid/ready) and every item gives exactly
// one result transfer on the out_ channel. A train item bumps the class count
// and one counter per feature; a predict item scores every class in use and
// returns the best one; a clear item zeroes all counters.
// The per-(feature, value, class) counters live in one RAM with a
// registered read; the class counts sit in flip-flops.
// Work per item, in the order of the RAM accesses:
//   train   read then write back each feature counter,
//   predict per class: prior, denominator, one counter read per cycle
//           for each feature, drain and compare,
//   clear   one entry written per cycle over the whole RAM.
// One item is worked on at a time; in_ready is high only while idle.
// After reset the block sweeps all NUM_FEATURES*NUM_VALUES*NUM_CLASSES RAM
// entries (256 by default) to zero before it takes its first item;
// configuration writes are taken at any time.
// The result sits in an output register, so the next item is accepted while
// a result still waits; a stalled receiver holds the next result back.
module naive_bayes_categorical_classifier_core #(
  parameter int NUM_FEATURES = nbc_pkg::NUM_FEATURES_DEF,
  parameter int NUM_VALUES   = nbc_pkg::NUM_VALUES_DEF,
  parameter int NUM_CLASSES  = nbc_pkg::NUM_CLASSES_DEF,
  parameter int COUNT_BITS   = nbc_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  nbc_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output nbc_pkg::out_result_t            out_data,
  input  logic                            cfg_we,
  input  logic [nbc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [nbc_pkg::CFG_W-1:0]       cfg_wdata
);

  localparam int DEPTH    = NUM_FEATURES * NUM_VALUES * NUM_CLASSES;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int CLS_W    = $clog2(NUM_CLASSES);
  localparam int F_W      = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
  localparam int F_CNT_W  = $clog2(NUM_FEATURES + 1);
  localparam int V_W      = $clog2(NUM_VALUES);
  localparam int NC_W     = $clog2(NUM_CLASSES + 1);
  localparam int NV_W     = $clog2(NUM_VALUES + 1);
  localparam int LA_W     = nbc_pkg::LOG_ARG_W;

  nbc_pkg::fsm_state_t  state_r, state_nxt;

  logic [2:0]           classes_r;
  logic [4:0]           features_r;
  logic [2:0]           values_r;

  logic [1:0]           op_r;
  logic [1:0]           label_r;
  logic [31:0]          row_r;
  logic                 item_r;
  logic [F_CNT_W-1:0]   feat_r;
  logic [CLS_W-1:0]     cls_r;
  logic [ADDR_W-1:0]    clr_addr_r;
  logic                 rd_valid_r;
  logic [COUNT_BITS-1:0] class_cnt_r [NUM_CLASSES];

  logic                 out_valid_r;
  nbc_pkg::out_result_t out_r;

  // Effective register values after clamping.
  logic [NC_W-1:0]      nc_eff;
  logic [F_CNT_W-1:0]   nf_eff;
  logic [NV_W-1:0]      nv_eff;

  logic                 accept;
  logic                 out_free;
  logic                 label_ok;
  logic [CLS_W-1:0]     label_idx;
  logic                 last_feat;
  logic                 last_cls;
  logic [1:0]           v_raw;
  logic [31:0]          v_mod;
  logic [F_W-1:0]       feat_idx;
  logic [V_W-1:0]       val_idx;
  logic [ADDR_W-1:0]    cell_addr;
  logic [COUNT_BITS-1:0] cls_cnt;

  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [COUNT_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [COUNT_BITS-1:0] ram_rdata;

  nbc_pkg::score_ctl_t  sc_ctl;
  logic [LA_W-1:0]      log_arg;
  logic                 sc_busy;
  logic [CLS_W-1:0]     best_cls;

  // Out-of-range register values are clamped into the usable range.
  always_comb begin
    if (classes_r == 3'd0) begin
      nc_eff = NC_W'(1);
    end else if (32'(classes_r) > NUM_CLASSES) begin
      nc_eff = NC_W'(NUM_CLASSES);
    end else begin
      nc_eff = NC_W'(classes_r);
    end
    if (32'(features_r) > NUM_FEATURES) begin
      nf_eff = F_CNT_W'(NUM_FEATURES);
    end else begin
      nf_eff = F_CNT_W'(features_r);
    end
    if (values_r == 3'd0) begin
      nv_eff = NV_W'(1);
    end else if (32'(values_r) > NUM_VALUES) begin
      nv_eff = NV_W'(NUM_VALUES);
    end else begin
      nv_eff = NV_W'(values_r);
    end
  end

  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign label_ok  = 32'(label_r) < 32'(nc_eff);
  assign label_idx = CLS_W'(label_r);
  assign last_feat = (32'(feat_r) + 32'd1) == 32'(nf_eff);
  assign last_cls  = (32'(cls_r) + 32'd1) == 32'(nc_eff);
  assign cls_cnt   = class_cnt_r[cls_r];

  // Feature value of the current feature; features past bit 31 read as zero,
  // and values past the value count wrap around.
  assign v_raw    = (32'(feat_r) < 32'd16) ? 2'(row_r >> {feat_r, 1'b0}) : 2'd0;
  assign v_mod    = (32'(v_raw) >= NUM_VALUES) ? 32'(v_raw) - 32'(NUM_VALUES) : 32'(v_raw);
  assign feat_idx = F_W'(feat_r);
  assign val_idx  = V_W'(v_mod);
  assign cell_addr = ADDR_W'((32'(feat_idx) * 32'(NUM_VALUES) + 32'(val_idx))
                             * 32'(NUM_CLASSES) + 32'(cls_r));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      nbc_pkg::S_CLEAR: begin
        if (clr_addr_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = item_r ? nbc_pkg::S_FIN : nbc_pkg::S_IDLE;
        end
      end
      nbc_pkg::S_IDLE: begin
        if (in_valid) begin
          case (in_data.operation)
            nbc_pkg::OP_TRAIN:   state_nxt = nbc_pkg::S_TR_CLS;
            nbc_pkg::OP_PREDICT: state_nxt = nbc_pkg::S_PR_PRIOR;
            nbc_pkg::OP_CLEAR:   state_nxt = nbc_pkg::S_CLEAR;
            default:             state_nxt = nbc_pkg::S_FIN;
          endcase
        end
      end
      nbc_pkg::S_TR_CLS: begin
        state_nxt = (label_ok && nf_eff != '0) ? nbc_pkg::S_TR_RD : nbc_pkg::S_FIN;
      end
      nbc_pkg::S_TR_RD:    state_nxt = nbc_pkg::S_TR_WR;
      nbc_pkg::S_TR_WR:    state_nxt = last_feat ? nbc_pkg::S_FIN : nbc_pkg::S_TR_RD;
      nbc_pkg::S_PR_PRIOR: state_nxt = nbc_pkg::S_PR_DENOM;
      nbc_pkg::S_PR_DENOM: begin
        state_nxt = (nf_eff == '0) ? nbc_pkg::S_PR_DRAIN : nbc_pkg::S_PR_ISSUE;
      end
      nbc_pkg::S_PR_ISSUE: state_nxt = last_feat ? nbc_pkg::S_PR_DRAIN : nbc_pkg::S_PR_ISSUE;
      nbc_pkg::S_PR_DRAIN: begin
        if (!rd_valid_r && !sc_busy) begin
          state_nxt = nbc_pkg::S_PR_CLASS;
        end
      end
      nbc_pkg::S_PR_CLASS: state_nxt = last_cls ? nbc_pkg::S_FIN : nbc_pkg::S_PR_PRIOR;
      nbc_pkg::S_FIN: begin
        if (out_free) begin
          state_nxt = nbc_pkg::S_IDLE;
        end
      end
      default: state_nxt = nbc_pkg::S_IDLE;
    endcase
  end

  // Memory and datapath controls per state.
  always_comb begin
    in_ready  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = cell_addr;
    ram_wdata = '0;
    ram_re    = 1'b0;
    sc_ctl    = '0;
    sc_ctl.rd_valid    = rd_valid_r;
    sc_ctl.first_class = (cls_r == '0);
    log_arg   = LA_W'(cls_cnt) + LA_W'(1);
    case (state_r)
      nbc_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_r;
      end
      nbc_pkg::S_IDLE:     in_ready = 1'b1;
      nbc_pkg::S_TR_RD:    ram_re = 1'b1;
      nbc_pkg::S_TR_WR: begin
        ram_we    = 1'b1;
        ram_wdata = (ram_rdata == '1) ? ram_rdata : ram_rdata + 1'b1;
      end
      nbc_pkg::S_PR_PRIOR: sc_ctl.prior_ld = 1'b1;
      nbc_pkg::S_PR_DENOM: begin
        sc_ctl.denom_ld = 1'b1;
        log_arg         = LA_W'(cls_cnt) + LA_W'(nv_eff);
      end
      nbc_pkg::S_PR_ISSUE: ram_re = 1'b1;
      nbc_pkg::S_PR_CLASS: sc_ctl.class_done = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nbc_pkg::S_CLEAR;
      classes_r   <= nbc_pkg::CLASSES_RST;
      features_r  <= nbc_pkg::FEATURES_RST;
      values_r    <= nbc_pkg::VALUES_RST;
      item_r      <= 1'b0;
      clr_addr_r  <= '0;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        class_cnt_r[i] <= '0;
      end
    end else begin
      state_r    <= state_nxt;
      rd_valid_r <= (state_r == nbc_pkg::S_PR_ISSUE);

      if (cfg_we) begin
        case (cfg_index)
          nbc_pkg::REG_CLASSES:  classes_r  <= cfg_wdata[2:0];
          nbc_pkg::REG_FEATURES: features_r <= cfg_wdata;
          nbc_pkg::REG_VALUES:   values_r   <= cfg_wdata[2:0];
          default: ;
        endcase
      end

      if (accept) begin
        item_r     <= 1'b1;
        clr_addr_r <= '0;
        if (in_data.operation == nbc_pkg::OP_CLEAR) begin
          for (int i = 0; i < NUM_CLASSES; i++) begin
            class_cnt_r[i] <= '0;
          end
        end
      end

      if (state_r == nbc_pkg::S_CLEAR) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end

      if (state_r == nbc_pkg::S_TR_CLS && label_ok &&
          class_cnt_r[label_idx] != '1) begin
        class_cnt_r[label_idx] <= class_cnt_r[label_idx] + 1'b1;
      end

      if (state_r == nbc_pkg::S_FIN && out_free) begin
        out_valid_r <= 1'b1;
        item_r      <= 1'b0;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_data.operation;
      label_r <= in_data.class_label;
      row_r   <= in_data.feature_values;
      cls_r   <= '0;
    end
    case (state_r)
      nbc_pkg::S_TR_CLS: begin
        cls_r  <= label_idx;
        feat_r <= '0;
      end
      nbc_pkg::S_TR_WR:    feat_r <= feat_r + 1'b1;
      nbc_pkg::S_PR_DENOM: feat_r <= '0;
      nbc_pkg::S_PR_ISSUE: feat_r <= feat_r + 1'b1;
      nbc_pkg::S_PR_CLASS: cls_r  <= cls_r + 1'b1;
      default: ;
    endcase
    if (state_r == nbc_pkg::S_FIN && out_free) begin
      if (op_r == nbc_pkg::OP_PREDICT) begin
        out_r.predicted_class <= 2'(best_cls);
        out_r.label_matches   <= (32'(best_cls) == 32'(label_r));
      end else begin
        out_r <= '0;
      end
    end
  end

  nbc_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (DEPTH)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (cell_addr),
    .rdata (ram_rdata)
  );

  nbc_score #(
    .NUM_FEATURES (NUM_FEATURES),
    .NUM_CLASSES  (NUM_CLASSES),
    .COUNT_BITS   (COUNT_BITS)
  ) u_score (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (sc_ctl),
    .cls      (cls_r),
    .log_arg  (log_arg),
    .rdata    (ram_rdata),
    .busy     (sc_busy),
    .best_cls (best_cls)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
